// ----- hw/rtl/lidar_packet_receiver_core_macros.svh -----
// assertion macros for the lidar packet receiver
// no dependencies; included by the top level only
`ifndef LIDAR_PACKET_RECEIVER_CORE_MACROS_SVH
`define LIDAR_PACKET_RECEIVER_CORE_MACROS_SVH

// same-cycle implication under synchronous reset
`define LPR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lpr assertion failed");

// next-cycle implication under synchronous reset
`define LPR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lpr assertion failed");

`endif

// ----- hw/rtl/lpr_pkg.sv -----
// shared types, constants and crc function for the lidar packet receiver
// no dependencies
package lpr_pkg;

    localparam int POINTS     = 12;
    localparam int FRAME_LEN  = 11 + 3 * POINTS;
    localparam int FILL_W     = $clog2(FRAME_LEN + 1);
    localparam int PT_IDX_W   = (POINTS > 1) ? $clog2(POINTS) : 1;
    localparam int PT_ADDR_W  = PT_IDX_W + 1;
    localparam int PT_DEPTH   = 2 ** PT_ADDR_W;
    localparam int SPEED_AT   = 2;
    localparam int FIRST_AT   = 4;
    localparam int PT_FIRST   = 6;
    localparam int PT_END     = PT_FIRST + 3 * POINTS;
    localparam int FINAL_AT   = PT_END;

    localparam logic [7:0] HDR_BYTE = 8'h54;
    localparam logic [7:0] LEN_BYTE = 8'h2C;
    localparam logic [7:0] CRC_POLY = 8'h4D;
    localparam logic [15:0] GAP_RESET = 16'd25;

    typedef struct packed {
        logic [7:0]  rx_byte;
        logic [31:0] arrival_ms;
    } t_in_word;

    typedef struct packed {
        logic        frame_good;
        logic [15:0] rotor_speed;
        logic [15:0] first_angle;
        logic [15:0] final_angle;
        logic [3:0]  point_number;
        logic [15:0] range_mm;
        logic [7:0]  strength;
        logic        last;
        logic [31:0] good_frames;
        logic [31:0] bad_frames;
    } t_out_word;

    typedef struct packed {
        logic [7:0]  strength;
        logic [15:0] range_mm;
    } t_pt_data;

    typedef struct packed {
        logic                 en;
        logic [PT_ADDR_W-1:0] addr;
        t_pt_data             data;
    } t_pt_wr;

    typedef struct packed {
        logic        start;
        logic        good;
        logic        bank;
        logic [15:0] rotor_speed;
        logic [15:0] first_angle;
        logic [15:0] final_angle;
        logic [31:0] good_frames;
        logic [31:0] bad_frames;
    } t_job;

    function automatic logic [7:0] crc_feed(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

// ----- hw/rtl/lidar_packet_receiver_core.sv -----
// top level of the lidar packet receiver: frame hunt, crc check, frame counters
// depends on lpr_pkg, lpr_point_drain and lidar_packet_receiver_core_macros.svh
//
// usage
//   input channel takes one received byte per word with its millisecond
//   timestamp; one word can be accepted every cycle. the byte that closes a
//   frame is held off (o_in_ready low) only while the previous frame's
//   results are still being read out of the point memory.
//   output channel gives one word per cycle while the receiver is ready:
//   POINTS words for a good frame, one word flagged bad for a failed crc; the
//   first result goes through job register, memory read and output register.
//   point words are kept in a two-bank point memory so the next frame fills
//   one bank while the drain reads the other; a stalled receiver only backs
//   up the drain and, at the end of the following frame, the input.
//   the config channel writes gap_timeout_ms and is always ready; write it
//   only while the block is idle.
//   reset (synchronous, active low) returns to header hunt, clears both frame
//   counters, drops pending results and sets the gap timeout to 25 ms.
`include "lidar_packet_receiver_core_macros.svh"

module lidar_packet_receiver_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  lpr_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output lpr_pkg::t_out_word o_out_word,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [15:0]        i_cfg_data
);

    typedef enum logic [1:0] {
        ST_HEADER  = 2'd0,
        ST_LENGTH  = 2'd1,
        ST_COLLECT = 2'd2
    } t_hunt;

    t_hunt                        r_state,    n_state;
    logic [lpr_pkg::FILL_W-1:0]   r_fill,     n_fill;
    logic [7:0]                   r_crc,      n_crc;
    logic [31:0]                  r_prev_ms,  n_prev_ms;
    logic [15:0]                  r_gap_ms;
    logic [31:0]                  r_good_cnt, n_good_cnt;
    logic [31:0]                  r_bad_cnt,  n_bad_cnt;
    logic                         r_wr_bank,  n_wr_bank;
    logic [lpr_pkg::PT_IDX_W-1:0] r_pt_idx,   n_pt_idx;
    logic [1:0]                   r_pt_phase, n_pt_phase;
    logic [15:0]                  r_speed,    n_speed;
    logic [15:0]                  r_first_ang, n_first_ang;
    logic [15:0]                  r_final_ang, n_final_ang;
    logic [7:0]                   r_pt_lo,    n_pt_lo;
    logic [7:0]                   r_pt_hi,    n_pt_hi;

    lpr_pkg::t_pt_wr pt_wr;
    lpr_pkg::t_job   job;
    logic            drain_busy;

    logic                       accept;
    logic [7:0]                 b;
    logic [31:0]                gap;
    logic                       drop;
    t_hunt                      eff_state;
    logic [lpr_pkg::FILL_W-1:0] eff_fill;
    logic [7:0]                 crc_cont;
    logic [7:0]                 crc_new;
    logic                       crc_ok;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !(r_state == ST_COLLECT
                           && r_fill == lpr_pkg::FILL_W'(lpr_pkg::FRAME_LEN - 1)
                           && drain_busy);
    assign accept    = i_in_valid && o_in_ready;
    assign b         = i_in_word.rx_byte;
    assign gap       = i_in_word.arrival_ms - r_prev_ms;
    assign drop      = (r_fill != '0) && (gap > {16'd0, r_gap_ms});
    assign eff_state = drop ? ST_HEADER : r_state;
    assign eff_fill  = drop ? '0 : r_fill;
    assign crc_cont  = lpr_pkg::crc_feed(r_crc, b);
    assign crc_new   = lpr_pkg::crc_feed(8'h00, b);
    assign crc_ok    = (r_crc == b);

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_crc       = r_crc;
        n_prev_ms   = r_prev_ms;
        n_good_cnt  = r_good_cnt;
        n_bad_cnt   = r_bad_cnt;
        n_wr_bank   = r_wr_bank;
        n_pt_idx    = r_pt_idx;
        n_pt_phase  = r_pt_phase;
        n_speed     = r_speed;
        n_first_ang = r_first_ang;
        n_final_ang = r_final_ang;
        n_pt_lo     = r_pt_lo;
        n_pt_hi     = r_pt_hi;
        pt_wr       = '0;
        job         = '0;
        job.bank        = r_wr_bank;
        job.rotor_speed = r_speed;
        job.first_angle = r_first_ang;
        job.final_angle = r_final_ang;
        job.good_frames = r_good_cnt;
        job.bad_frames  = r_bad_cnt;

        if (accept) begin
            n_prev_ms = i_in_word.arrival_ms;
            if (drop) begin
                n_state = ST_HEADER;
                n_fill  = '0;
            end
            unique case (eff_state)
                ST_LENGTH: begin
                    if (b == lpr_pkg::LEN_BYTE) begin
                        n_crc      = crc_cont;
                        n_fill     = lpr_pkg::FILL_W'(2);
                        n_state    = ST_COLLECT;
                        n_pt_idx   = '0;
                        n_pt_phase = 2'd0;
                    end else if (b == lpr_pkg::HDR_BYTE) begin
                        n_crc   = crc_new;
                        n_fill  = lpr_pkg::FILL_W'(1);
                        n_state = ST_LENGTH;
                    end else begin
                        n_fill  = '0;
                        n_state = ST_HEADER;
                    end
                end
                ST_COLLECT: begin
                    if (eff_fill == lpr_pkg::FILL_W'(lpr_pkg::FRAME_LEN - 1)) begin
                        n_fill    = '0;
                        n_state   = ST_HEADER;
                        job.start = 1'b1;
                        job.good  = crc_ok;
                        if (crc_ok) begin
                            n_good_cnt      = r_good_cnt + 32'd1;
                            n_wr_bank       = !r_wr_bank;
                            job.good_frames = n_good_cnt;
                        end else begin
                            n_bad_cnt      = r_bad_cnt + 32'd1;
                            job.bad_frames = n_bad_cnt;
                        end
                    end else begin
                        n_crc  = crc_cont;
                        n_fill = lpr_pkg::FILL_W'(eff_fill + 1'b1);
                        if (eff_fill == lpr_pkg::FILL_W'(lpr_pkg::SPEED_AT)) begin
                            n_speed[7:0] = b;
                        end
                        if (eff_fill == lpr_pkg::FILL_W'(lpr_pkg::SPEED_AT + 1)) begin
                            n_speed[15:8] = b;
                        end
                        if (eff_fill == lpr_pkg::FILL_W'(lpr_pkg::FIRST_AT)) begin
                            n_first_ang[7:0] = b;
                        end
                        if (eff_fill == lpr_pkg::FILL_W'(lpr_pkg::FIRST_AT + 1)) begin
                            n_first_ang[15:8] = b;
                        end
                        if (eff_fill == lpr_pkg::FILL_W'(lpr_pkg::FINAL_AT)) begin
                            n_final_ang[7:0] = b;
                        end
                        if (eff_fill == lpr_pkg::FILL_W'(lpr_pkg::FINAL_AT + 1)) begin
                            n_final_ang[15:8] = b;
                        end
                        if (eff_fill >= lpr_pkg::FILL_W'(lpr_pkg::PT_FIRST)
                            && eff_fill < lpr_pkg::FILL_W'(lpr_pkg::PT_END)) begin
                            // distance low, distance high, intensity
                            unique case (r_pt_phase)
                                2'd0: begin
                                    n_pt_lo    = b;
                                    n_pt_phase = 2'd1;
                                end
                                2'd1: begin
                                    n_pt_hi    = b;
                                    n_pt_phase = 2'd2;
                                end
                                default: begin
                                    pt_wr.en            = 1'b1;
                                    pt_wr.addr          = {r_wr_bank, r_pt_idx};
                                    pt_wr.data.strength = b;
                                    pt_wr.data.range_mm = {r_pt_hi, r_pt_lo};
                                    n_pt_idx   = lpr_pkg::PT_IDX_W'(r_pt_idx + 1'b1);
                                    n_pt_phase = 2'd0;
                                end
                            endcase
                        end
                    end
                end
                default: begin
                    if (b == lpr_pkg::HDR_BYTE) begin
                        n_crc   = crc_new;
                        n_fill  = lpr_pkg::FILL_W'(1);
                        n_state = ST_LENGTH;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_HEADER;
            r_fill     <= '0;
            r_crc      <= 8'h00;
            r_prev_ms  <= 32'd0;
            r_gap_ms   <= lpr_pkg::GAP_RESET;
            r_good_cnt <= 32'd0;
            r_bad_cnt  <= 32'd0;
            r_wr_bank  <= 1'b0;
            r_pt_idx   <= '0;
            r_pt_phase <= 2'd0;
        end else begin
            r_state    <= n_state;
            r_fill     <= n_fill;
            r_crc      <= n_crc;
            r_prev_ms  <= n_prev_ms;
            r_good_cnt <= n_good_cnt;
            r_bad_cnt  <= n_bad_cnt;
            r_wr_bank  <= n_wr_bank;
            r_pt_idx   <= n_pt_idx;
            r_pt_phase <= n_pt_phase;
            if (i_cfg_valid && o_cfg_ready) begin
                r_gap_ms <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_speed     <= n_speed;
        r_first_ang <= n_first_ang;
        r_final_ang <= n_final_ang;
        r_pt_lo     <= n_pt_lo;
        r_pt_hi     <= n_pt_hi;
    end

    lpr_point_drain u_drain (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pt_wr     (pt_wr),
        .i_job       (job),
        .o_busy      (drain_busy),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

    `LPR_ASSERT_NOW(a_job_into_idle_drain, i_clk, i_rst_n, job.start, !drain_busy)
    `LPR_ASSERT_NEXT(a_job_makes_busy, i_clk, i_rst_n, job.start, drain_busy)
    `LPR_ASSERT_NOW(a_result_from_drain, i_clk, i_rst_n, $rose(o_out_valid), $past(drain_busy))

endmodule

// ----- hw/rtl/lpr_point_drain.sv -----
// point store and result drain: two-bank point memory, read stage, output register
// depends on lpr_pkg
module lpr_point_drain (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lpr_pkg::t_pt_wr   i_pt_wr,
    input  lpr_pkg::t_job     i_job,
    output logic              o_busy,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output lpr_pkg::t_out_word o_out_word
);

    lpr_pkg::t_pt_data mem [lpr_pkg::PT_DEPTH];

    logic                         r_job_active;
    logic                         r_job_good;
    logic                         r_job_bank;
    logic [lpr_pkg::PT_IDX_W-1:0] r_job_idx;
    logic [15:0]                  r_speed;
    logic [15:0]                  r_first_ang;
    logic [15:0]                  r_final_ang;
    logic [31:0]                  r_good_cnt;
    logic [31:0]                  r_bad_cnt;

    logic                         r_rd_valid;
    logic                         r_rd_good;
    logic                         r_rd_last;
    logic [lpr_pkg::PT_IDX_W-1:0] r_rd_idx;
    lpr_pkg::t_pt_data            r_rd_data;

    logic                         r_out_valid;
    lpr_pkg::t_out_word           r_out_word;
    lpr_pkg::t_out_word           n_out_word;

    logic out_load;
    logic issue;
    logic issue_last;

    assign out_load   = r_rd_valid && (!r_out_valid || i_out_ready);
    assign issue      = r_job_active && (!r_rd_valid || out_load);
    assign issue_last = !r_job_good
                        || (r_job_idx == lpr_pkg::PT_IDX_W'(lpr_pkg::POINTS - 1));

    assign o_busy      = r_job_active || r_rd_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // bad frame: all point fields zero, single result
    always_comb begin
        n_out_word             = '0;
        n_out_word.frame_good  = r_rd_good;
        n_out_word.last        = r_rd_last;
        n_out_word.good_frames = r_good_cnt;
        n_out_word.bad_frames  = r_bad_cnt;
        if (r_rd_good) begin
            n_out_word.rotor_speed  = r_speed;
            n_out_word.first_angle  = r_first_ang;
            n_out_word.final_angle  = r_final_ang;
            n_out_word.point_number = 4'(r_rd_idx);
            n_out_word.range_mm     = r_rd_data.range_mm;
            n_out_word.strength     = r_rd_data.strength;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pt_wr.en) begin
            mem[i_pt_wr.addr] <= i_pt_wr.data;
        end
        if (issue) begin
            r_rd_data <= mem[{r_job_bank, r_job_idx}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_active <= 1'b0;
            r_rd_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_job.start) begin
                r_job_active <= 1'b1;
            end else if (issue && issue_last) begin
                r_job_active <= 1'b0;
            end
            if (issue) begin
                r_rd_valid <= 1'b1;
            end else if (out_load) begin
                r_rd_valid <= 1'b0;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_job.start) begin
            r_job_good  <= i_job.good;
            r_job_bank  <= i_job.bank;
            r_job_idx   <= '0;
            r_speed     <= i_job.rotor_speed;
            r_first_ang <= i_job.first_angle;
            r_final_ang <= i_job.final_angle;
            r_good_cnt  <= i_job.good_frames;
            r_bad_cnt   <= i_job.bad_frames;
        end else if (issue) begin
            r_job_idx <= lpr_pkg::PT_IDX_W'(r_job_idx + 1'b1);
        end
        if (issue) begin
            r_rd_good <= r_job_good;
            r_rd_last <= issue_last;
            r_rd_idx  <= r_job_idx;
        end
        if (out_load) begin
            r_out_word <= n_out_word;
        end
    end

endmodule
